>>> src/rotation_matrix_to_quaternion_core_assert.svh
// Assertion macros for the rotation matrix to quaternion core checker.
// Uses no package; clock and reset are passed in by the caller.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

`endif

>>> src/rmq_pkg.sv
// Shared constants, types and the output saturation helper for the
// rotation matrix to quaternion core. No dependencies.
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int ONE       = 1 << FRAC_BITS;

    // radicand path
    localparam int RW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int RMW  = RW - 1;
    localparam int RADW = RMW + FRAC_BITS + 2;
    localparam int SQW  = (RADW + 1) / 2;
    localparam int RADP = 2 * SQW;

    // division path
    localparam int NW   = IN_W + 1;
    localparam int DW   = ((NW + FRAC_BITS > SQW) ? NW + FRAC_BITS : SQW) + 1;
    localparam int QB   = FRAC_BITS + 1;
    localparam int MW0  = (QB > SQW) ? QB : SQW;
    localparam int MW   = (MW0 > OUT_W + 1) ? MW0 : OUT_W + 1;

    localparam int HI_MAG = (ONE < 32767) ? ONE : 32767;
    localparam int LO_MAG = (ONE < 32768) ? ONE : 32768;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } t_branch;

    typedef struct packed {
        t_branch               br;
        logic [2:0][NW-1:0]    n;
    } t_sq_side;

    typedef struct packed {
        t_branch          br;
        logic [SQW-1:0]   s;
        logic [SQW-1:0]   own;
        logic [2:0]       neg;
        logic [2:0]       ovf;
    } t_dv_side;

    function automatic logic [OUT_W-1:0] sat16(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0] c;
        logic [MW-1:0] v;
        if (neg) begin
            c = (mag > MW'(LO_MAG)) ? MW'(LO_MAG) : mag;
            v = MW'(0) - c;
        end else begin
            c = (mag > MW'(HI_MAG)) ? MW'(HI_MAG) : mag;
            v = c;
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

>>> src/rotation_matrix_to_quaternion_core.sv
// Pipeline from accepted input to output valid, for Q1.14 data: one branch
// stage, one square-root stage per root bit, one division setup stage, one
// restoring-division stage per quotient bit, one output register.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output register is stalled. Synchronous active-low reset clears valid bits only.
module rotation_matrix_to_quaternion_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [15:0]        i_first_axis_x,
    input  logic signed [15:0]        i_first_axis_y,
    input  logic signed [15:0]        i_first_axis_z,
    input  logic signed [15:0]        i_second_axis_x,
    input  logic signed [15:0]        i_second_axis_y,
    input  logic signed [15:0]        i_second_axis_z,
    input  logic signed [15:0]        i_third_axis_x,
    input  logic signed [15:0]        i_third_axis_y,
    input  logic signed [15:0]        i_third_axis_z,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [15:0]        o_quat_w,
    output logic signed [15:0]        o_quat_x,
    output logic signed [15:0]        o_quat_y,
    output logic signed [15:0]        o_quat_z
);

    localparam int RW   = rmq_pkg::RW;
    localparam int RMW  = rmq_pkg::RMW;
    localparam int SQW  = rmq_pkg::SQW;
    localparam int RADP = rmq_pkg::RADP;
    localparam int NW   = rmq_pkg::NW;
    localparam int DW   = rmq_pkg::DW;
    localparam int QB   = rmq_pkg::QB;
    localparam int MW   = rmq_pkg::MW;
    localparam int FB   = rmq_pkg::FRAC_BITS;

    localparam logic signed [RW-1:0] ONE_R = RW'(rmq_pkg::ONE);

    logic en;
    logic r_out_vld;

    assign o_stall = r_out_vld && i_stall;
    assign en      = !o_stall;

    // ---------------- branch select and radicand ----------------
    logic signed [RW-1:0] t_sum, r_raw, r_clamp;
    logic signed [RW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    rmq_pkg::t_branch     n_br;
    logic [2:0][NW-1:0]   n_num;

    assign ax = RW'(i_first_axis_x);
    assign ay = RW'(i_first_axis_y);
    assign az = RW'(i_first_axis_z);
    assign bx = RW'(i_second_axis_x);
    assign by = RW'(i_second_axis_y);
    assign bz = RW'(i_second_axis_z);
    assign cx = RW'(i_third_axis_x);
    assign cy = RW'(i_third_axis_y);
    assign cz = RW'(i_third_axis_z);
    assign t_sum = ax + by + cz;

    always_comb begin
        if (t_sum > 0) begin
            n_br     = rmq_pkg::BR_W;
            r_raw    = ONE_R + t_sum;
            n_num[0] = NW'(bz - cy);
            n_num[1] = NW'(cx - az);
            n_num[2] = NW'(ay - bx);
        end else if (ax > by && ax > cz) begin
            n_br     = rmq_pkg::BR_X;
            r_raw    = ONE_R + ax - by - cz;
            n_num[0] = NW'(bz - cy);
            n_num[1] = NW'(bx + ay);
            n_num[2] = NW'(cx + az);
        end else if (by > cz) begin
            n_br     = rmq_pkg::BR_Y;
            r_raw    = ONE_R + by - ax - cz;
            n_num[0] = NW'(cx - az);
            n_num[1] = NW'(bx + ay);
            n_num[2] = NW'(cy + bz);
        end else begin
            n_br     = rmq_pkg::BR_Z;
            r_raw    = ONE_R + cz - ax - by;
            n_num[0] = NW'(ay - bx);
            n_num[1] = NW'(cx + az);
            n_num[2] = NW'(cy + bz);
        end
        // clamp a non-positive radicand to one LSB
        r_clamp = (r_raw < RW'(1)) ? RW'(1) : r_raw;
    end

    logic                r_s0_vld;
    logic [RADP-1:0]     r_s0_rad;
    rmq_pkg::t_sq_side   r_s0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_rad     <= RADP'({r_clamp[RMW-1:0], {(FB + 2){1'b0}}});
            r_s0_side.br <= n_br;
            r_s0_side.n  <= n_num;
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    logic                r_sq_vld  [SQW];
    logic [SQW:0]        r_sq_rem  [SQW];
    logic [SQW-1:0]      r_sq_root [SQW];
    logic [RADP-1:0]     r_sq_rad  [SQW];
    rmq_pkg::t_sq_side   r_sq_side [SQW];

    genvar k;
    generate
        for (k = 0; k < SQW; k++) begin : g_sq
            logic              p_vld;
            logic [SQW:0]      p_rem;
            logic [SQW-1:0]    p_root;
            logic [RADP-1:0]   p_rad;
            rmq_pkg::t_sq_side p_side;
            logic [SQW+2:0]    rem2, trial;
            logic              take;

            if (k == 0) begin : g_first
                assign p_vld  = r_s0_vld;
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_rad  = r_s0_rad;
                assign p_side = r_s0_side;
            end else begin : g_next
                assign p_vld  = r_sq_vld[k-1];
                assign p_rem  = r_sq_rem[k-1];
                assign p_root = r_sq_root[k-1];
                assign p_rad  = r_sq_rad[k-1];
                assign p_side = r_sq_side[k-1];
            end

            assign rem2  = {p_rem, p_rad[RADP-1:RADP-2]};
            assign trial = (SQW+3)'({p_root, 2'b01});
            assign take  = rem2 >= trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[k] <= 1'b0;
                end else if (en) begin
                    r_sq_vld[k] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_rem[k]  <= take ? (SQW+1)'(rem2 - trial) : rem2[SQW:0];
                    r_sq_root[k] <= {p_root[SQW-2:0], take};
                    r_sq_rad[k]  <= {p_rad[RADP-3:0], 2'b00};
                    r_sq_side[k] <= p_side;
                end
            end
        end
    endgenerate

    // ---------------- division setup ----------------
    logic [SQW-1:0]  s_val;
    logic [SQW:0]    own_sum;
    logic [2:0]      d_neg, d_ovf;
    logic [SQW:0]    d_rem0 [3];
    logic [QB-1:0]   d_low  [3];

    assign s_val   = r_sq_root[SQW-1];
    assign own_sum = (SQW+1)'(s_val) + (SQW+1)'(2);

    genvar m;
    generate
        for (m = 0; m < 3; m++) begin : g_dprep
            logic signed [NW-1:0] num;
            logic [NW-1:0]        mag;
            logic [DW-1:0]        dvd;
            logic [DW-QB-1:0]     hi;
            assign num      = $signed(r_sq_side[SQW-1].n[m]);
            assign mag      = num[NW-1] ? NW'(-num) : NW'(num);
            assign dvd      = DW'({mag, {FB{1'b0}}}) + DW'(s_val >> 1);
            assign hi       = dvd[DW-1:QB];
            assign d_neg[m] = num[NW-1];
            assign d_ovf[m] = hi >= (DW-QB)'(s_val);
            assign d_rem0[m] = (SQW+1)'(hi[SQW-1:0]);
            assign d_low[m]  = dvd[QB-1:0];
        end
    endgenerate

    logic                r_dp_vld;
    logic [SQW:0]        r_dp_rem [3];
    logic [QB-1:0]       r_dp_low [3];
    rmq_pkg::t_dv_side   r_dp_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp_vld <= 1'b0;
        end else if (en) begin
            r_dp_vld <= r_sq_vld[SQW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dp_rem      <= d_rem0;
            r_dp_low      <= d_low;
            r_dp_side.br  <= r_sq_side[SQW-1].br;
            r_dp_side.s   <= s_val;
            r_dp_side.own <= SQW'(own_sum[SQW:2]);
            r_dp_side.neg <= d_neg;
            r_dp_side.ovf <= d_ovf;
        end
    end

    // ---------------- restoring division, one quotient bit per stage ----------------
    logic                r_dv_vld  [QB];
    logic [SQW:0]        r_dv_rem  [QB][3];
    logic [QB-1:0]       r_dv_low  [QB][3];
    rmq_pkg::t_dv_side   r_dv_side [QB];

    genvar j;
    generate
        for (j = 0; j < QB; j++) begin : g_dv
            logic              p_vld;
            logic [SQW:0]      p_rem [3];
            logic [QB-1:0]     p_low [3];
            rmq_pkg::t_dv_side p_side;
            logic [SQW:0]      n_rem [3];
            logic [QB-1:0]     n_low [3];

            if (j == 0) begin : g_first
                assign p_vld  = r_dp_vld;
                assign p_rem  = r_dp_rem;
                assign p_low  = r_dp_low;
                assign p_side = r_dp_side;
            end else begin : g_next
                assign p_vld  = r_dv_vld[j-1];
                assign p_rem  = r_dv_rem[j-1];
                assign p_low  = r_dv_low[j-1];
                assign p_side = r_dv_side[j-1];
            end

            for (m = 0; m < 3; m++) begin : g_lane
                logic [SQW:0] rem2;
                logic         take;
                assign rem2     = {p_rem[m][SQW-1:0], p_low[m][QB-1]};
                assign take     = rem2 >= (SQW+1)'(p_side.s);
                assign n_rem[m] = take ? rem2 - (SQW+1)'(p_side.s) : rem2;
                // shift the quotient bit in behind the dividend bits
                assign n_low[m] = {p_low[m][QB-2:0], take};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[j] <= 1'b0;
                end else if (en) begin
                    r_dv_vld[j] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_rem[j]  <= n_rem;
                    r_dv_low[j]  <= n_low;
                    r_dv_side[j] <= p_side;
                end
            end
        end
    endgenerate

    // ---------------- saturate, place and register ----------------
    rmq_pkg::t_dv_side f_side;
    logic [15:0]       q_part [3];
    logic [15:0]       q_own;
    logic [15:0]       n_w, n_x, n_y, n_z;

    assign f_side = r_dv_side[QB-1];
    assign q_own  = rmq_pkg::sat16(1'b0, MW'(f_side.own));

    generate
        for (m = 0; m < 3; m++) begin : g_sat
            logic [MW-1:0] mag;
            assign mag       = f_side.ovf[m] ? {MW{1'b1}} : MW'(r_dv_low[QB-1][m]);
            assign q_part[m] = rmq_pkg::sat16(f_side.neg[m], mag);
        end
    endgenerate

    always_comb begin
        case (f_side.br)
            rmq_pkg::BR_W: begin
                n_w = q_own;     n_x = q_part[0]; n_y = q_part[1]; n_z = q_part[2];
            end
            rmq_pkg::BR_X: begin
                n_w = q_part[0]; n_x = q_own;     n_y = q_part[1]; n_z = q_part[2];
            end
            rmq_pkg::BR_Y: begin
                n_w = q_part[0]; n_x = q_part[1]; n_y = q_own;     n_z = q_part[2];
            end
            default: begin
                n_w = q_part[0]; n_x = q_part[1]; n_y = q_part[2]; n_z = q_own;
            end
        endcase
    end

    logic [15:0] r_quat_w, r_quat_x, r_quat_y, r_quat_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv_vld[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_quat_w <= n_w;
            r_quat_x <= n_x;
            r_quat_y <= n_y;
            r_quat_z <= n_z;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_quat_w = $signed(r_quat_w);
    assign o_quat_x = $signed(r_quat_x);
    assign o_quat_y = $signed(r_quat_y);
    assign o_quat_z = $signed(r_quat_z);

endmodule

>>> src/rmq_chk.sv
// Port-level checker for the rotation matrix to quaternion core, bound to the top.
// Depends on rmq_pkg and the assertion macro header.
`include "rotation_matrix_to_quaternion_core_assert.svh"

module rmq_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [15:0] i_first_axis_x,
    input  logic signed [15:0] i_first_axis_y,
    input  logic signed [15:0] i_first_axis_z,
    input  logic signed [15:0] i_second_axis_x,
    input  logic signed [15:0] i_second_axis_y,
    input  logic signed [15:0] i_second_axis_z,
    input  logic signed [15:0] i_third_axis_x,
    input  logic signed [15:0] i_third_axis_y,
    input  logic signed [15:0] i_third_axis_z,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [15:0] o_quat_w,
    input  logic signed [15:0] o_quat_x,
    input  logic signed [15:0] o_quat_y,
    input  logic signed [15:0] o_quat_z
);

    logic in_range;

    // every component is saturated to plus or minus one
    assign in_range = int'(o_quat_w) <= rmq_pkg::HI_MAG && int'(o_quat_w) >= -rmq_pkg::LO_MAG &&
                      int'(o_quat_x) <= rmq_pkg::HI_MAG && int'(o_quat_x) >= -rmq_pkg::LO_MAG &&
                      int'(o_quat_y) <= rmq_pkg::HI_MAG && int'(o_quat_y) >= -rmq_pkg::LO_MAG &&
                      int'(o_quat_z) <= rmq_pkg::HI_MAG && int'(o_quat_z) >= -rmq_pkg::LO_MAG;

    // input side stalls only because a finished result is held at the output
    `RMQ_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    `RMQ_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    `RMQ_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, o_valid && i_stall, $stable({o_quat_w, o_quat_x, o_quat_y, o_quat_z}))

    `RMQ_ASSERT_NOW(a_range, i_clk, i_rst_n, o_valid, in_range)

endmodule

bind rotation_matrix_to_quaternion_core rmq_chk u_rmq_chk (.*);

>>> verif/tb_top.sv
// Self-checking testbench for rotation_matrix_to_quaternion_core.
// Drives frames through the valid/stall handshake and checks each quaternion
// against a fixed answer or a behavioral Shepperd predictor; depends only on the RTL.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic signed [15:0] m [9];
    } t_frame;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    typedef struct {
        t_frame f;
        logic   has_quat;
        t_quat  q;
    } t_vector;

    localparam int  ONE_Q  = 16384;
    localparam int  WD_MAX = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic signed [15:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
    logic signed [15:0] cx = '0, cy = '0, cz = '0;
    logic signed [15:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;

    t_quat   quat_fifo [$];
    t_vector vec_table [$];
    int      n_err = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      wd_cnt = 0;

    always #10 i_clk = ~i_clk;

    rotation_matrix_to_quaternion_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_first_axis_x(ax), .i_first_axis_y(ay), .i_first_axis_z(az),
        .i_second_axis_x(bx), .i_second_axis_y(by), .i_second_axis_z(bz),
        .i_third_axis_x(cx), .i_third_axis_y(cy), .i_third_axis_z(cz),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_quat_w(o_quat_w), .o_quat_x(o_quat_x), .o_quat_y(o_quat_y),
        .o_quat_z(o_quat_z)
    );

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint div_round(longint num, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        q = ((mag << 14) + (s >> 1)) / s;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [15:0] clamp_q(longint v);
        if (v > ONE_Q) v = ONE_Q;
        if (v < -ONE_Q) v = -ONE_Q;
        return v[15:0];
    endfunction

    function automatic t_quat frame_to_quat(t_frame f);
        longint m00, m10, m20, m01, m11, m21, m02, m12, m22, tr, rad, n0, n1, n2, own;
        longint unsigned s;
        longint p [4];
        int br;
        t_quat q;
        m00 = f.m[0]; m10 = f.m[1]; m20 = f.m[2];
        m01 = f.m[3]; m11 = f.m[4]; m21 = f.m[5];
        m02 = f.m[6]; m12 = f.m[7]; m22 = f.m[8];
        tr = m00 + m11 + m22;
        if (tr > 0) begin
            br = 0; rad = ONE_Q + tr;
            n0 = m21 - m12; n1 = m02 - m20; n2 = m10 - m01;
        end else if (m00 > m11 && m00 > m22) begin
            br = 1; rad = ONE_Q + m00 - m11 - m22;
            n0 = m21 - m12; n1 = m01 + m10; n2 = m02 + m20;
        end else if (m11 > m22) begin
            br = 2; rad = ONE_Q + m11 - m00 - m22;
            n0 = m02 - m20; n1 = m01 + m10; n2 = m12 + m21;
        end else begin
            br = 3; rad = ONE_Q + m22 - m00 - m11;
            n0 = m10 - m01; n1 = m02 + m20; n2 = m12 + m21;
        end
        if (rad < 1) rad = 1;
        s = int_sqrt(longint'(rad) << 16);
        own = (s + 2) >> 2;
        // own part goes in the branch slot, the three quotients fill the rest in order
        p[br] = own;
        p[(br == 0) ? 1 : 0] = div_round(n0, s);
        p[(br <= 1) ? 2 : 1] = div_round(n1, s);
        p[(br <= 2) ? 3 : 2] = div_round(n2, s);
        q.w = clamp_q(p[0]); q.x = clamp_q(p[1]);
        q.y = clamp_q(p[2]); q.z = clamp_q(p[3]);
        return q;
    endfunction

    function automatic t_quat mk_quat(int w, int x, int y, int z);
        t_quat q;
        q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
        return q;
    endfunction

    function automatic t_frame mk_frame(int a0, int a1, int a2, int b0, int b1, int b2,
                                        int c0, int c1, int c2);
        t_frame f;
        f.m[0] = 16'(a0); f.m[1] = 16'(a1); f.m[2] = 16'(a2);
        f.m[3] = 16'(b0); f.m[4] = 16'(b1); f.m[5] = 16'(b2);
        f.m[6] = 16'(c0); f.m[7] = 16'(c1); f.m[8] = 16'(c2);
        return f;
    endfunction

    function automatic logic signed [15:0] any_word();
        case ($urandom_range(0, 5))
            0: return 16'(ONE_Q);
            1: return -16'(ONE_Q);
            2: return 16'($urandom());
            default: return 16'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
        endcase
    endfunction

    // random proper rotation: quaternion of random content, normalized, expanded
    function automatic t_frame rot_frame();
        real qw, qx, qy, qz, nrm;
        real r [9];
        t_frame f;
        qw = $itor($urandom_range(0, 2000)) - 1000.0;
        qx = $itor($urandom_range(0, 2000)) - 1000.0;
        qy = $itor($urandom_range(0, 2000)) - 1000.0;
        qz = $itor($urandom_range(0, 2000)) - 1000.0;
        nrm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz) + 1.0e-9;
        qw /= nrm; qx /= nrm; qy /= nrm; qz /= nrm;
        r[0] = 1 - 2 * (qy * qy + qz * qz); r[1] = 2 * (qx * qy + qz * qw);
        r[2] = 2 * (qx * qz - qy * qw);     r[3] = 2 * (qx * qy - qz * qw);
        r[4] = 1 - 2 * (qx * qx + qz * qz); r[5] = 2 * (qy * qz + qx * qw);
        r[6] = 2 * (qx * qz + qy * qw);     r[7] = 2 * (qy * qz - qx * qw);
        r[8] = 1 - 2 * (qx * qx + qy * qy);
        for (int k = 0; k < 9; k++) f.m[k] = 16'($rtoi(r[k] * ONE_Q));
        return f;
    endfunction

    task automatic send_frame(t_frame f, logic has_quat, t_quat q);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        ax <= f.m[0]; ay <= f.m[1]; az <= f.m[2];
        bx <= f.m[3]; by <= f.m[4]; bz <= f.m[5];
        cx <= f.m[6]; cy <= f.m[7]; cz <= f.m[8];
        i_valid <= 1'b1;
        quat_fifo.insert(quat_fifo.size(), has_quat ? q : frame_to_quat(f));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic check_field(string nm, logic signed [15:0] exp_v, logic signed [15:0] got);
        if (exp_v !== got) begin
            $error("%s: expected %0d, got %0d", nm, exp_v, got);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) wd_cnt <= 0;
            else wd_cnt <= wd_cnt + 1;
            if (o_valid && !i_stall) begin
                if (quat_fifo.size() == 0) begin
                    $error("unexpected quaternion transaction");
                    n_err++;
                end else begin
                    check_field("quat_w", quat_fifo[0].w, o_quat_w);
                    check_field("quat_x", quat_fifo[0].x, o_quat_x);
                    check_field("quat_y", quat_fifo[0].y, o_quat_y);
                    check_field("quat_z", quat_fifo[0].z, o_quat_z);
                    void'(quat_fifo.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (wd_cnt >= WD_MAX) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        t_vector v;
        t_frame  f;
        int      pick;

        // identity and the three half turns have exact answers; the rest go
        // through the predictor
        v.has_quat = 1'b1; v.f = mk_frame(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q);
        v.q = mk_quat(ONE_Q, 0, 0, 0); vec_table.insert(vec_table.size(), v);
        v.f = mk_frame(ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q);
        v.q = mk_quat(0, ONE_Q, 0, 0); vec_table.insert(vec_table.size(), v);
        v.f = mk_frame(-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q);
        v.q = mk_quat(0, 0, ONE_Q, 0); vec_table.insert(vec_table.size(), v);
        v.f = mk_frame(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q);
        v.q = mk_quat(0, 0, 0, ONE_Q); vec_table.insert(vec_table.size(), v);
        v.has_quat = 1'b0;
        // all zero: trace zero, ties fall through to the last branch
        v.f = mk_frame(0, 0, 0, 0, 0, 0, 0, 0, 0); vec_table.insert(vec_table.size(), v);
        // diagonal of minus one, one, one: the trace is positive, so the w branch is taken
        v.f = mk_frame(-16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
        vec_table.insert(vec_table.size(), v);
        v.f = mk_frame(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767);
        vec_table.insert(vec_table.size(), v);
        v.f = mk_frame(32767, -32768, 32767, -32768, -32768, -32768, 32767, 32767, -32768);
        vec_table.insert(vec_table.size(), v);
        v.f = mk_frame(-1, -1, -1, -1, -1, -1, -1, -1, -1);
        vec_table.insert(vec_table.size(), v);
        v.f = mk_frame(-100, 5000, -5000, 9000, -100, 3000, -7000, 2000, -200);
        vec_table.insert(vec_table.size(), v);
        v.f = mk_frame(-200, 0, 0, 0, -100, 0, 0, 0, -300);
        vec_table.insert(vec_table.size(), v);
        v.f = mk_frame(-300, 1, 2, 3, -300, 4, 5, 6, -100);
        vec_table.insert(vec_table.size(), v);
        v.f = mk_frame(1, -32768, 32767, 32767, 1, -32768, -32768, 32767, 1);
        vec_table.insert(vec_table.size(), v);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vec_table[k]) send_frame(vec_table[k].f, vec_table[k].has_quat,
                                          vec_table[k].q);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            for (int n = 0; n < 400; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    f = rot_frame();
                end else begin
                    for (int k = 0; k < 9; k++) f.m[k] = any_word();
                end
                // keep a stretch of each phase free of idling
                if (n >= 350) idle_pct = 0;
                send_frame(f, 1'b0, v.q);
            end
        end
        i_valid <= 1'b0;
        stall_pct = 10;
        while (quat_fifo.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_err == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> rotation_matrix_to_quaternion_core.f
+incdir+src
src/rmq_pkg.sv
src/rotation_matrix_to_quaternion_core.sv
src/rmq_chk.sv
verif/tb_top.sv
